FILE: rtl/iee_pkg.sv
// package for the infix expression evaluator: payload structs, codes, helpers
// no dependencies
package iee_pkg;

    localparam int OpDepthDefault    = 16;
    localparam int ValueDepthDefault = 16;
    localparam int QueueDepth        = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_item_t;

    // operator codes as kept on the operator stack
    typedef enum logic [2:0] {
        OPC_NONE  = 3'd0,
        OPC_PAREN = 3'd1,
        OPC_BRACK = 3'd2,
        OPC_ADD   = 3'd3,
        OPC_SUB   = 3'd4,
        OPC_MUL   = 3'd5,
        OPC_DIV   = 3'd6
    } opc_t;

    // status codes of a result
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISSING  = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_FULL     = 3'd3,
        ST_BRACKET  = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    // character classes found by the front end
    typedef enum logic [2:0] {
        CLS_IGNORE = 3'd0,
        CLS_DIGIT  = 3'd1,
        CLS_OPEN   = 3'd2,
        CLS_CLOSE  = 3'd3,
        CLS_OP     = 3'd4
    } cls_t;

    // classified transaction handed from front to back
    typedef struct packed {
        cls_t       cls;
        opc_t       opc;
        logic [3:0] digit;
        logic       last;
    } tok_t;

    localparam logic [7:0] ChZero  = 8'd48;
    localparam logic [7:0] ChNine  = 8'd57;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChStar  = 8'h2A;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChLpar  = 8'h28;
    localparam logic [7:0] ChLbrk  = 8'h5B;
    localparam logic [7:0] ChRpar  = 8'h29;
    localparam logic [7:0] ChRbrk  = 8'h5D;

    // precedence of an operator already on the stack
    function automatic logic [2:0] prec_in(input opc_t op);
        logic [2:0] p;
        p = 3'd1;
        if (op == OPC_ADD || op == OPC_SUB) p = 3'd3;
        if (op == OPC_MUL || op == OPC_DIV) p = 3'd5;
        return p;
    endfunction

endpackage

FILE: rtl/iee_front.sv
// front end: input queue port, character classification, token fifo
// depends on iee_pkg
module iee_front
    import iee_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_item,
    input  logic     push,
    output logic     full,
    output tok_t     tok,
    output logic     tok_valid,
    input  logic     tok_take
);

    localparam int PtrW = $clog2(QueueDepth);

    tok_t            fifo_mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   cnt_reg;
    tok_t            cls_tok;
    logic            do_push, do_pop;

    // classify one character
    always_comb
    begin
        cls_tok       = '0;
        cls_tok.cls   = CLS_IGNORE;
        cls_tok.opc   = OPC_NONE;
        cls_tok.last  = in_item.last;
        cls_tok.digit = 4'(in_item.ch - ChZero);
        if (in_item.ch >= ChZero && in_item.ch <= ChNine)
            cls_tok.cls = CLS_DIGIT;
        else if (in_item.ch == ChLpar)
        begin
            cls_tok.cls = CLS_OPEN;  cls_tok.opc = OPC_PAREN;
        end
        else if (in_item.ch == ChLbrk)
        begin
            cls_tok.cls = CLS_OPEN;  cls_tok.opc = OPC_BRACK;
        end
        else if (in_item.ch == ChRpar)
        begin
            cls_tok.cls = CLS_CLOSE; cls_tok.opc = OPC_PAREN;
        end
        else if (in_item.ch == ChRbrk)
        begin
            cls_tok.cls = CLS_CLOSE; cls_tok.opc = OPC_BRACK;
        end
        else if (in_item.ch == ChPlus)
        begin
            cls_tok.cls = CLS_OP;    cls_tok.opc = OPC_ADD;
        end
        else if (in_item.ch == ChMinus)
        begin
            cls_tok.cls = CLS_OP;    cls_tok.opc = OPC_SUB;
        end
        else if (in_item.ch == ChStar)
        begin
            cls_tok.cls = CLS_OP;    cls_tok.opc = OPC_MUL;
        end
        else if (in_item.ch == ChSlash)
        begin
            cls_tok.cls = CLS_OP;    cls_tok.opc = OPC_DIV;
        end
    end

    assign full      = (cnt_reg == (PtrW+1)'(QueueDepth));
    assign tok_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = tok_take && tok_valid;
    assign tok       = fifo_mem[rd_ptr_reg];

    // token fifo storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            fifo_mem[wr_ptr_reg] <= cls_tok;
    end

    // fifo pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(QueueDepth)) else $error("fifo count overrun");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("fifo count not bumped");
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!tok_valid && !do_push) |=> !tok_valid) else $error("fifo filled itself");
`endif

endmodule

FILE: rtl/iee_divider.sv
// restoring divider: 48-bit dividend magnitude over 32-bit divisor magnitude
// depends on iee_pkg
module iee_divider
    import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted, diff;

    assign shifted  = {rem_reg[31:0], q_reg[47]};
    assign diff     = shifted - {1'b0, d_reg};
    assign quotient = q_reg;
    assign done     = busy_reg && (cnt_reg == 6'd0);

    // one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd48;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0) busy_reg <= 1'b0;
            else                 cnt_reg  <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/iee_back.sv
// back end: operator stack, value stack, sequencer and result register
// depends on iee_pkg, iee_divider
module iee_back
    import iee_pkg::*;
#(
    parameter int OP_DEPTH    = OpDepthDefault,
    parameter int VALUE_DEPTH = ValueDepthDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_t      tok,
    input  logic      tok_valid,
    output logic      tok_take,
    output out_item_t out_item,
    output logic      empty,
    input  logic      pop
);

    localparam int OpW = $clog2(OP_DEPTH);
    localparam int VW  = $clog2(VALUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOP, S_MUL, S_DIV, S_WB, S_FINISH, S_EMIT
    } bstate_t;

    opc_t               op_mem [OP_DEPTH];
    logic signed [31:0] val_mem [VALUE_DEPTH];

    bstate_t            state_reg, state_next;
    logic [OpW:0]       opc_reg, opc_next;
    logic [VW:0]        vc_reg, vc_next;
    logic [2:0]         err_reg, err_next;
    tok_t               cur_reg, cur_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;
    logic signed [31:0] res_reg, res_next;
    logic               neg_reg, neg_next;
    logic [63:0]        prod_reg, prod_next;

    opc_t               top_op;
    logic signed [31:0] va, vb;
    logic [31:0]        ma, mb;
    logic               op_we, v_we;
    logic [OpW-1:0]     op_wa;
    opc_t               op_wd;
    logic [VW-1:0]      v_wa;
    logic signed [31:0] v_wd;
    logic               div_start, div_done;
    logic [47:0]        div_q;
    logic [47:0]        mag_r;
    logic               fit;
    logic signed [32:0] sum;

    assign top_op = (opc_reg != '0) ? op_mem[OpW'(opc_reg - 1'b1)] : OPC_NONE;
    assign vb     = (vc_reg >= (VW+1)'(1)) ? val_mem[VW'(vc_reg - 1'b1)] : '0;
    assign va     = (vc_reg >= (VW+1)'(2)) ? val_mem[VW'(vc_reg - 2'd2)] : '0;
    assign ma     = va[31] ? 32'(-va) : 32'(va);
    assign mb     = vb[31] ? 32'(-vb) : 32'(vb);
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    iee_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({ma, 16'd0}),
        .divisor  (mb),
        .done     (div_done),
        .quotient (div_q)
    );

    // stack memories
    always_ff @(posedge clk)
    begin
        if (op_we) op_mem[op_wa] <= op_wd;
        if (v_we)  val_mem[v_wa] <= v_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            opc_reg       <= '0;
            vc_reg        <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            opc_reg       <= opc_next;
            vc_reg        <= vc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        out_reg  <= out_next;
        res_reg  <= res_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
    end

    // sequencer: one stack action per cycle, waiting on the divider and on result pop
    always_comb
    begin
        state_next     = state_reg;
        opc_next       = opc_reg;
        vc_next        = vc_reg;
        err_next       = err_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        tok_take       = 1'b0;
        op_we          = 1'b0;
        op_wa          = OpW'(opc_reg);
        op_wd          = cur_reg.opc;
        v_we           = 1'b0;
        v_wa           = VW'(vc_reg);
        v_wd           = signed'({12'd0, cur_reg.digit, 16'd0});
        div_start      = 1'b0;
        mag_r          = '0;
        fit            = 1'b0;
        sum            = '0;

        if (out_valid_reg && pop)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_take   = 1'b1;
                    cur_next   = tok;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                // one step of handling the current character
                if (err_reg != ST_OK)
                    state_next = S_FINISH;
                else
                begin
                    priority case (cur_reg.cls)
                        CLS_DIGIT:
                        begin
                            if (vc_reg >= (VW+1)'(VALUE_DEPTH)) err_next = ST_FULL;
                            else
                            begin
                                v_we    = 1'b1;
                                vc_next = vc_reg + 1'b1;
                            end
                            state_next = S_FINISH;
                        end
                        CLS_OPEN:
                        begin
                            if (opc_reg >= (OpW+1)'(OP_DEPTH)) err_next = ST_FULL;
                            else
                            begin
                                op_we    = 1'b1;
                                opc_next = opc_reg + 1'b1;
                            end
                            state_next = S_FINISH;
                        end
                        CLS_CLOSE:
                        begin
                            if (opc_reg != '0 && top_op >= OPC_ADD)
                                state_next = S_WB;
                            else
                            begin
                                if (opc_reg == '0 || top_op != cur_reg.opc)
                                    err_next = ST_BRACKET;
                                else
                                    opc_next = opc_reg - 1'b1;
                                state_next = S_FINISH;
                            end
                        end
                        CLS_OP:
                        begin
                            if (opc_reg != '0 && prec_in(top_op) >=
                                ((cur_reg.opc == OPC_ADD || cur_reg.opc == OPC_SUB)
                                 ? 3'd2 : 3'd4))
                                state_next = S_WB;
                            else
                            begin
                                if (opc_reg >= (OpW+1)'(OP_DEPTH)) err_next = ST_FULL;
                                else
                                begin
                                    op_we    = 1'b1;
                                    opc_next = opc_reg + 1'b1;
                                end
                                state_next = S_FINISH;
                            end
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_WB:
            begin
                // pop one operator and start applying it
                opc_next = opc_reg - 1'b1;
                neg_next = va[31] ^ vb[31];
                if (vc_reg < (VW+1)'(2))
                begin
                    err_next   = ST_MISSING;
                    state_next = S_LOOP;
                end
                else if (top_op == OPC_ADD || top_op == OPC_SUB)
                begin
                    sum = (top_op == OPC_ADD) ? (33'(va) + 33'(vb)) : (33'(va) - 33'(vb));
                    if (sum[32] != sum[31]) err_next = ST_OVERFLOW;
                    else
                    begin
                        v_we    = 1'b1;
                        v_wa    = VW'(vc_reg - 2'd2);
                        v_wd    = sum[31:0];
                        vc_next = vc_reg - 1'b1;
                    end
                    state_next = S_LOOP;
                end
                else if (top_op == OPC_MUL)
                begin
                    prod_next  = 64'(ma) * 64'(mb);
                    state_next = S_MUL;
                end
                else
                begin
                    if (vb == '0)
                    begin
                        err_next   = ST_DIVZERO;
                        state_next = S_LOOP;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL, S_DIV:
            begin
                mag_r = (state_reg == S_MUL) ? prod_reg[63:16] : div_q;
                fit   = neg_reg ? (mag_r <= 48'h8000_0000) : (mag_r <= 48'h7FFF_FFFF);
                if (state_reg == S_MUL || div_done)
                begin
                    if (!fit) err_next = ST_OVERFLOW;
                    else
                    begin
                        v_we    = 1'b1;
                        v_wa    = VW'(vc_reg - 2'd2);
                        v_wd    = neg_reg ? 32'(-mag_r[31:0]) : mag_r[31:0];
                        vc_next = vc_reg - 1'b1;
                    end
                    state_next = (cur_reg.last && cur_reg.cls == CLS_IGNORE)
                                 ? S_FINISH : S_LOOP;
                end
            end
            S_FINISH:
            begin
                // on the last character drain remaining operators, else return to idle
                if (!cur_reg.last)
                    state_next = S_IDLE;
                else if (err_reg == ST_OK && opc_reg != '0)
                begin
                    cur_next.cls = CLS_IGNORE;
                    if (top_op < OPC_ADD)
                        err_next = ST_BRACKET;
                    else
                        state_next = S_WB;
                end
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = (err_reg != ST_OK) ? err_reg :
                                      (vc_reg == '0) ? ST_EMPTY : ST_OK;
                    out_next.value  = (err_reg == ST_OK && vc_reg != '0) ? vb : '0;
                    opc_next        = '0;
                    vc_next         = '0;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // after a pop in drain mode, return to the drain step
        if ((state_reg == S_WB) && cur_reg.last && cur_reg.cls == CLS_IGNORE
            && state_next == S_LOOP)
            state_next = S_FINISH;
    end

`ifndef SYNTH
    a_op_bound: assert property (@(posedge clk) disable iff (!rst_n)
        opc_reg <= (OpW+1)'(OP_DEPTH)) else $error("operator stack overrun");
    a_val_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= (VW+1)'(VALUE_DEPTH)) else $error("value stack overrun");
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |=>
        (opc_reg == '0 && vc_reg == '0 && err_reg == ST_OK))
        else $error("stacks not cleared after result");
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |-> out_reg.value == '0)
        else $error("error result carries a value");
`endif

endmodule

FILE: rtl/infix_expression_evaluator.sv
// infix expression evaluator, top level
// depends on iee_pkg, iee_front, iee_back
//
// Usage: characters enter as in_item {ch, last} on a queue-like port
// (push/full); a transaction happens when push is high and full is low.
// The result {value, status} leaves on a queue-like port (empty/pop); a
// transaction happens when pop is high and empty is low.
// A front end classifies characters into a 4-entry token fifo; the back end
// works the operator and value stacks one action per cycle, waiting while the
// divider runs or a held result is not popped. A divide uses the restoring
// divider, one quotient bit per cycle. The result is registered once the
// last character's operators are applied.
// Only the character marked last produces a result; then both stacks and
// the error code clear.
// Reset clears the fifo, both stack counts, the error code and the result.
// When the receiver stalls, one result is held; the back end waits with the
// next result and the fifo fills until full rises.
module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int OP_DEPTH    = OpDepthDefault,
    parameter int VALUE_DEPTH = ValueDepthDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      push,
    output logic      full,
    output out_item_t out_item,
    output logic      empty,
    input  logic      pop
);

    tok_t tok;
    logic tok_valid, tok_take;

    iee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .push      (push),
        .full      (full),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_take  (tok_take)
    );

    iee_back #(
        .OP_DEPTH    (OP_DEPTH),
        .VALUE_DEPTH (VALUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_take  (tok_take),
        .out_item  (out_item),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

FILE: test/iee_checker.sv
// checker for the infix expression evaluator: watches both channels,
// predicts results with its own shunting-yard model and compares them
// depends on iee_pkg
`timescale 1ns / 100ps

module iee_checker
    import iee_pkg::*;
#(
    parameter int OP_DEPTH    = OpDepthDefault,
    parameter int VALUE_DEPTH = ValueDepthDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      push,
    input  logic      full,
    input  out_item_t out_item,
    input  logic      empty,
    input  logic      pop,
    output int        fail_count,
    output int        pending
);

    // predictor state
    opc_t        ops [OP_DEPTH];
    int          n_ops;
    logic [31:0] vals [VALUE_DEPTH];
    int          n_vals;
    status_t     err;
    out_item_t   results_due [$];

    assign pending = results_due.size();

    function automatic int op_rank(opc_t op);
        if (op == OPC_ADD || op == OPC_SUB) return 3;
        if (op == OPC_MUL || op == OPC_DIV) return 5;
        return 1;
    endfunction

    function automatic void raise(status_t s);
        if (err == ST_OK) err = s;
    endfunction

    // apply one operator to the two top values
    function automatic void apply_op(opc_t op);
        logic signed [63:0] a, b, r;
        logic [63:0] ma, mb, m;
        logic neg;
        if (n_vals < 2)
        begin
            raise(ST_MISSING);
            return;
        end
        b = {{32{vals[n_vals-1][31]}}, vals[n_vals-1]};
        a = {{32{vals[n_vals-2][31]}}, vals[n_vals-2]};
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r = 0;
        case (op)
            OPC_ADD: r = a + b;
            OPC_SUB: r = a - b;
            OPC_MUL:
            begin
                m = (ma * mb) >> 16;
                if (neg ? m > 64'h8000_0000 : m > 64'h7FFF_FFFF)
                begin
                    raise(ST_OVERFLOW);
                    return;
                end
                r = neg ? -m : m;
            end
            default:
            begin
                if (b == 0)
                begin
                    raise(ST_DIVZERO);
                    return;
                end
                m = (ma << 16) / mb;
                if (neg ? m > 64'h8000_0000 : m > 64'h7FFF_FFFF)
                begin
                    raise(ST_OVERFLOW);
                    return;
                end
                r = neg ? -m : m;
            end
        endcase
        if (r > 64'sh7FFF_FFFF || r < -64'sh8000_0000)
        begin
            raise(ST_OVERFLOW);
            return;
        end
        n_vals = n_vals - 1;
        vals[n_vals-1] = r[31:0];
    endfunction

    function automatic void pop_apply();
        n_ops = n_ops - 1;
        apply_op(ops[n_ops]);
    endfunction

    function automatic void take_char(logic [7:0] c);
        opc_t op, want;
        int outp;
        if (c >= ChZero && c <= ChNine)
        begin
            if (n_vals >= VALUE_DEPTH) raise(ST_FULL);
            else
            begin
                vals[n_vals] = (32'(c) - 32'd48) << 16;
                n_vals++;
            end
            return;
        end
        if (c == ChLpar || c == ChLbrk)
        begin
            if (n_ops >= OP_DEPTH) raise(ST_FULL);
            else
            begin
                ops[n_ops] = (c == ChLpar) ? OPC_PAREN : OPC_BRACK;
                n_ops++;
            end
            return;
        end
        if (c == ChRpar || c == ChRbrk)
        begin
            want = (c == ChRpar) ? OPC_PAREN : OPC_BRACK;
            while (err == ST_OK && n_ops > 0 && ops[n_ops-1] >= OPC_ADD) pop_apply();
            if (err != ST_OK) return;
            if (n_ops == 0 || ops[n_ops-1] != want) raise(ST_BRACKET);
            else n_ops--;
            return;
        end
        if (c == ChPlus) op = OPC_ADD;
        else if (c == ChMinus) op = OPC_SUB;
        else if (c == ChStar) op = OPC_MUL;
        else if (c == ChSlash) op = OPC_DIV;
        else return;
        outp = (op == OPC_ADD || op == OPC_SUB) ? 2 : 4;
        while (err == ST_OK && n_ops > 0 && op_rank(ops[n_ops-1]) >= outp) pop_apply();
        if (err != ST_OK) return;
        if (n_ops >= OP_DEPTH) raise(ST_FULL);
        else
        begin
            ops[n_ops] = op;
            n_ops++;
        end
    endfunction

    // one input transaction: update the model, queue a result on last
    function automatic void predict_char(in_item_t it);
        out_item_t res;
        if (err == ST_OK) take_char(it.ch);
        if (!it.last) return;
        while (err == ST_OK && n_ops > 0)
        begin
            if (ops[n_ops-1] < OPC_ADD)
            begin
                raise(ST_BRACKET);
                break;
            end
            pop_apply();
        end
        res.status = err;
        if (err == ST_OK && n_vals == 0) res.status = ST_EMPTY;
        res.value = (res.status == ST_OK) ? vals[n_vals-1] : 32'd0;
        results_due.push_back(res);
        n_ops = 0;
        n_vals = 0;
        err = ST_OK;
    endfunction

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            n_ops = 0;
            n_vals = 0;
            err = ST_OK;
            fail_count <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with none expected: value %0d status %0d",
                           out_item.value, out_item.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status,
                               out_item.status);
                        fail_count <= fail_count + 1;
                    end
                    else if (out_item.value !== want.value)
                    begin
                        $error("value: expected %0d actual %0d", want.value,
                               out_item.value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (push && !full) predict_char(in_item);
        end
    end

endmodule

FILE: test/tb_infix_expression_evaluator.sv
// testbench top for the infix expression evaluator: clock, reset,
// directed and random expressions, receiver stalls and the verdict
// depends on iee_pkg, iee_checker, infix_expression_evaluator
`timescale 1ns / 100ps

module tb_infix_expression_evaluator;
    import iee_pkg::*;

    logic      clk;
    logic      rst_n;
    in_item_t  in_item;
    logic      push;
    logic      full;
    out_item_t out_item;
    logic      empty;
    logic      pop;
    int        fail_count;
    int        pending;
    int        cycle_count;
    bit        hold_rx;
    bit        stim_done;
    logic [7:0] char_buf [$];
    logic       last_buf [$];

    infix_expression_evaluator u_top (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .out_item(out_item), .empty(empty), .pop(pop)
    );

    iee_checker u_check (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .out_item(out_item), .empty(empty), .pop(pop),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // operator character for index k, one of + - * /
    function automatic logic [7:0] pick_sym(int k);
        case (k)
            0: return ChPlus;
            1: return ChMinus;
            2: return ChStar;
            default: return ChSlash;
        endcase
    endfunction

    // queue one expression; its final character is marked last
    task automatic add_expr(string s);
        foreach (s[i])
        begin
            char_buf.push_back(s[i]);
            last_buf.push_back(i == s.len() - 1);
        end
    endtask

    task automatic add_random_expr();
        int n, depth, mode;
        logic [7:0] c;
        mode = $urandom_range(0, 9);
        n = $urandom_range(1, 7);
        depth = 0;
        if (mode == 0)
        begin
            // raw noise with any byte
            repeat (n)
            begin
                char_buf.push_back(8'($urandom));
                last_buf.push_back(1'b0);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 4) == 0 && depth < 3)
                begin
                    c = $urandom_range(0, 1) ? ChLpar : ChLbrk;
                    char_buf.push_back(c);
                    last_buf.push_back(1'b0);
                    depth++;
                end
                char_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
                last_buf.push_back(1'b0);
                if (depth > 0 && $urandom_range(0, 2) == 0)
                begin
                    char_buf.push_back($urandom_range(0, 1) ? ChRpar : ChRbrk);
                    last_buf.push_back(1'b0);
                    depth--;
                end
                if (i < n - 1)
                begin
                    char_buf.push_back(pick_sym($urandom_range(0, 3)));
                    last_buf.push_back(1'b0);
                end
            end
            while (depth > 0 && mode != 1)
            begin
                char_buf.push_back(ChRpar);
                last_buf.push_back(1'b0);
                depth--;
            end
        end
        char_buf.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h20);
        last_buf.push_back(1'b1);
    endtask

    // send queued characters in bursts, with random gaps after some bursts
    task automatic send_all();
        int burst;
        while (char_buf.size() > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && char_buf.size() > 0)
            begin
                push <= 1'b1;
                in_item <= '{ch: char_buf[0], last: last_buf[0]};
                @(posedge clk);
                while (full) @(posedge clk);
                void'(char_buf.pop_front());
                void'(last_buf.pop_front());
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                push <= 1'b0;
                in_item <= '{ch: 8'($urandom), last: 1'($urandom)};
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // receiver stall pattern and one long hold-off
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx) pop <= 1'b0;
            else if (cycle_count % 64 < 20) pop <= ($urandom_range(0, 3) == 0);
            else pop <= 1'b1;
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000)
        begin
            $display("infix_expression_evaluator regression: fail");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        hold_rx = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed expressions
        add_expr("9*9*9*9+0");
        add_expr("1/0");
        add_expr("(1+2]");
        add_expr("+");
        add_expr("x");
        add_expr("[3-8]*(2/7)");
        add_expr("((1");
        add_expr("2)");
        add_expr("9*9*9*9*9*9*9*9");
        add_expr("0-9*9*9*9*9*9*9*9*9");
        add_expr("1 2 3");
        add_expr("0123456789012345678");
        add_expr("((((((((((((((((((1");
        add_expr("9/7-8/3");
        add_expr("\xff");
        send_all();
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_rx = 1'b1;
        repeat (20) add_random_expr();
        fork
            send_all();
            begin
                for (int i = 0; i < 400; i++) @(posedge clk);
                hold_rx = 1'b0;
            end
        join
        drain();

        // random phase
        while (char_buf.size() < 220)
        begin
            add_random_expr();
        end
        send_all();
        drain();
        stim_done = 1'b1;

        if (fail_count == 0)
            $display("infix_expression_evaluator regression: pass");
        else
            $display("infix_expression_evaluator regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_divider.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator.sv
test/iee_checker.sv
test/tb_infix_expression_evaluator.sv
